// File: hw/rtl/fmqd_pkg.sv
// shared types, constants and arctangent table of the fm quadrature discriminator
package fmqd_pkg;

  // defaults for the top level parameters
  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // samples are scaled so that they sit at 32 fractional-turn bits;
  // three guard bits cover the negation of the most negative value and cordic gain
  localparam int Z_W        = 32;
  localparam int XY_W       = Z_W + 3;
  localparam int TABLE_LEN  = 24;

  localparam logic [Z_W-1:0] Z_HALF_TURN = 32'h8000_0000;

  // atan(2^-k) in units of 2^-32 turn, rounded
  localparam logic [Z_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // data handed from one cell to the next
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
    logic                   zero;
    logic                   start;
  } cordic_data_t;

endpackage

// File: hw/rtl/fm_quadrature_discriminator_unit.sv
// top level of the fm quadrature discriminator: cordic cell chain and phase differencer
//
// Takes one complex sample (in_i_sample, in_q_sample) per request and returns one
// out_freq_step per request: the phase atan2(q, i) as a binary angle, minus the
// phase of the previous sample, wrapped into [-pi, pi) where 2^(ANGLE_WIDTH-1)
// stands for pi. A request with in_block_start set is measured against a previous
// phase of zero; a zero sample has phase zero, and a difference of exactly +pi
// reads as -pi. Throughput is one request per clock while out_stall is low.
// CORDIC_STAGES + 2 registers sit between the ports: one entry cell, one cell per
// cordic micro-rotation, one differencing cell, passed through in that order. Each
// cell holds one request, so the chain keeps accepting while a finished result
// waits, until every cell is full.
module fm_quadrature_discriminator_unit #(
  parameter int SAMPLE_WIDTH  = fmqd_pkg::SAMPLE_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = fmqd_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = fmqd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_i_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] in_q_sample,
  input  logic                          in_block_start,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ANGLE_WIDTH-1:0] out_freq_step
);

  // links between cells; link CORDIC_STAGES feeds the differencer
  logic                   link_valid [CORDIC_STAGES+1];
  logic                   link_stall [CORDIC_STAGES+1];
  fmqd_pkg::cordic_data_t link_data  [CORDIC_STAGES+1];

  // scaling and half-plane fold
  fmqd_prerot #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_prerot (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_i     (in_i_sample),
    .up_q     (in_q_sample),
    .up_start (in_block_start),
    .dn_valid (link_valid[0]),
    .dn_stall (link_stall[0]),
    .dn_data  (link_data[0])
  );

  // chain of micro-rotation cells, shift and table angle fixed per cell
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    fmqd_cell #(
      .K(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[g]),
      .up_stall (link_stall[g]),
      .up_data  (link_data[g]),
      .dn_valid (link_valid[g+1]),
      .dn_stall (link_stall[g+1]),
      .dn_data  (link_data[g+1])
    );
  end

  // rounding, difference against the stored phase, output register
  fmqd_diff #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_diff (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (link_valid[CORDIC_STAGES]),
    .up_stall     (link_stall[CORDIC_STAGES]),
    .up_data      (link_data[CORDIC_STAGES]),
    .dn_valid     (out_valid),
    .dn_stall     (out_stall),
    .dn_freq_step (out_freq_step)
  );

  // back-pressure reaches the input only when the whole chain is held by the output
  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // a result appears only after the last cordic cell handed one over
  a_result_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(link_valid[CORDIC_STAGES]))
    else $error("result appeared from an empty chain");

  // a zero sample opening a block gives a zero step
  a_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    (link_valid[CORDIC_STAGES] && !link_stall[CORDIC_STAGES] &&
     link_data[CORDIC_STAGES].zero && link_data[CORDIC_STAGES].start)
    |=> (out_freq_step == '0))
    else $error("zero sample at block start gave a non-zero step");

endmodule

// File: hw/rtl/fmqd_prerot.sv
// entry cell: scales the sample and folds the left half-plane onto the right
module fmqd_prerot #(
  parameter int SAMPLE_WIDTH = fmqd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] up_i,
  input  logic signed [SAMPLE_WIDTH-1:0] up_q,
  input  logic                           up_start,
  output logic                           dn_valid,
  input  logic                           dn_stall,
  output fmqd_pkg::cordic_data_t         dn_data
);

  localparam int PAD_LO = fmqd_pkg::Z_W - SAMPLE_WIDTH;
  localparam int PAD_HI = fmqd_pkg::XY_W - fmqd_pkg::Z_W;

  logic                   valid_r;
  fmqd_pkg::cordic_data_t data_r;
  fmqd_pkg::cordic_data_t data_nxt;
  logic                   load;
  logic signed [fmqd_pkg::XY_W-1:0] xi;
  logic signed [fmqd_pkg::XY_W-1:0] yi;

  assign load     = !valid_r || !dn_stall;
  assign up_stall = !load;

  always_comb begin
    xi = {{PAD_HI{up_i[SAMPLE_WIDTH-1]}}, up_i, {PAD_LO{1'b0}}};
    yi = {{PAD_HI{up_q[SAMPLE_WIDTH-1]}}, up_q, {PAD_LO{1'b0}}};
    data_nxt.zero  = (up_i == '0) && (up_q == '0);
    data_nxt.start = up_start;
    if (xi[fmqd_pkg::XY_W-1]) begin
      data_nxt.x = -xi;
      data_nxt.y = -yi;
      data_nxt.z = fmqd_pkg::Z_HALF_TURN;
    end else begin
      data_nxt.x = xi;
      data_nxt.y = yi;
      data_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: hw/rtl/fmqd_cell.sv
// one cordic vectoring micro-rotation cell with its own pipeline register
module fmqd_cell #(
  parameter int K = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_stall,
  input  fmqd_pkg::cordic_data_t up_data,
  output logic                   dn_valid,
  input  logic                   dn_stall,
  output fmqd_pkg::cordic_data_t dn_data
);

  localparam logic [fmqd_pkg::Z_W-1:0] ANGLE = fmqd_pkg::ATAN_TURNS[K];

  logic                   valid_r;
  fmqd_pkg::cordic_data_t data_r;
  fmqd_pkg::cordic_data_t data_nxt;
  logic                   load;
  logic signed [fmqd_pkg::XY_W-1:0] dx;
  logic signed [fmqd_pkg::XY_W-1:0] dy;

  assign load     = !valid_r || !dn_stall;
  assign up_stall = !load;

  always_comb begin
    dx = up_data.y >>> K;
    dy = up_data.x >>> K;
    data_nxt.zero  = up_data.zero;
    data_nxt.start = up_data.start;
    // rotate towards the positive real axis
    if (!up_data.y[fmqd_pkg::XY_W-1]) begin
      data_nxt.x = up_data.x + dx;
      data_nxt.y = up_data.y - dy;
      data_nxt.z = up_data.z + ANGLE;
    end else begin
      data_nxt.x = up_data.x - dx;
      data_nxt.y = up_data.y + dy;
      data_nxt.z = up_data.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: hw/rtl/fmqd_diff.sv
// exit cell: rounds the angle, differences it against the stored phase
module fmqd_diff #(
  parameter int ANGLE_WIDTH = fmqd_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_stall,
  input  fmqd_pkg::cordic_data_t        up_data,
  output logic                          dn_valid,
  input  logic                          dn_stall,
  output logic signed [ANGLE_WIDTH-1:0] dn_freq_step
);

  localparam logic [fmqd_pkg::Z_W-1:0] ROUND_HALF =
    fmqd_pkg::Z_W'(1) << (fmqd_pkg::Z_W - 1 - ANGLE_WIDTH);

  logic                          valid_r;
  logic signed [ANGLE_WIDTH-1:0] freq_r;
  logic [ANGLE_WIDTH-1:0]        freq_nxt;
  logic [ANGLE_WIDTH-1:0]        last_phase_r;
  logic [ANGLE_WIDTH-1:0]        phase;
  logic [ANGLE_WIDTH-1:0]        prev;
  logic [fmqd_pkg::Z_W-1:0]      z_round;
  logic                          load;

  assign load     = !valid_r || !dn_stall;
  assign up_stall = !load;

  always_comb begin
    z_round  = up_data.z + ROUND_HALF;
    phase    = up_data.zero ? '0 : z_round[fmqd_pkg::Z_W-1 -: ANGLE_WIDTH];
    prev     = up_data.start ? '0 : last_phase_r;
    // modular difference, wraps into [-pi, pi)
    freq_nxt = phase - prev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      last_phase_r <= '0;
    end else if (load) begin
      valid_r <= up_valid;
      if (up_valid) begin
        last_phase_r <= phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      freq_r <= signed'(freq_nxt);
    end
  end

  assign dn_valid     = valid_r;
  assign dn_freq_step = freq_r;

endmodule
